FILE: rtl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// XTEA package
// Constants, register codes and the round sum function for the XTEA encipher.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

  localparam int unsigned DefMaxRounds = 32;
  localparam int unsigned WordW        = 32;
  localparam int unsigned RoundCountW  = 6;
  localparam int unsigned CfgIndexW    = 3;

  localparam logic [WordW-1:0]       XteaDelta     = 32'h9E37_79B9;
  localparam logic [RoundCountW-1:0] RoundCountRst = 6'd32;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_KEY_A       = 3'd0,
    CFG_KEY_B       = 3'd1,
    CFG_KEY_C       = 3'd2,
    CFG_KEY_D       = 3'd3,
    CFG_ROUND_COUNT = 3'd4
  } cfg_index_t;

  // Round sum after r additions of the constant, modulo 2^32.
  function automatic logic [WordW-1:0] xtea_sum(input int unsigned r);
    logic [63:0] prod;
    prod = 64'(r) * 64'(XteaDelta);
    return prod[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/xtea_cell.sv
// ----------------------------------------------------------------------------
// XTEA half-round cell
// One registered Feistel half-round. The word pair is swapped on the way
// through, so identical cells chain without any reordering.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_cell
  import xtea_pkg::*;
#(
  parameter logic [WordW-1:0] SUM = '0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             active,
  input  wire logic [WordW-1:0] key,
  input  wire logic             in_valid,
  input  wire logic [WordW-1:0] in_p,
  input  wire logic [WordW-1:0] in_q,
  output logic                  out_valid,
  output logic [WordW-1:0]      out_p,
  output logic [WordW-1:0]      out_q
);

  logic             valid_r;
  logic [WordW-1:0] p_r;
  logic [WordW-1:0] q_r;
  logic [WordW-1:0] mix_w;
  logic [WordW-1:0] keyed_w;
  logic [WordW-1:0] q_nxt;

  always_comb begin
    mix_w   = ((in_q << 4) ^ (in_q >> 5)) + in_q;
    keyed_w = SUM + key;
    q_nxt   = active ? (in_p + (mix_w ^ keyed_w)) : in_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
    if (adv) begin
      p_r <= in_q;
      q_r <= q_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_p     = p_r;
  assign out_q     = q_r;

endmodule

`default_nettype wire

FILE: rtl/xtea_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// XTEA block encipher
// Enciphers 64-bit blocks with a 128-bit key held in configuration registers.
//
//   Channel  Direction  Beat contents
//   in_      slave      tdata: plain_first [31:0], plain_second [63:32]
//   out_     master     tdata: cipher_first [31:0], cipher_second [63:32]
//   cfg_     slave      index 0..3 key words a..d, index 4 round count
//
// One block is accepted per cycle while the chain is not held; each block passes
// through the chain of half-round cells, one registered cell after another.
// Rounds beyond the configured count pass the words through unchanged.
// When the output beat is not taken, the whole chain holds.
// Reset clears the valid bits, the key words, and sets the round count to 32.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_block_encrypt_top
  import xtea_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = DefMaxRounds
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [2*WordW-1:0]   in_tdata,   // plain_first, plain_second
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [2*WordW-1:0]        out_tdata,  // cipher_first, cipher_second
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [WordW-1:0]     cfg_data
);

  localparam int unsigned NumCells = 2 * MAX_ROUNDS;
  localparam logic [RoundCountW:0] MaxRoundsW = (RoundCountW+1)'(MAX_ROUNDS);

  logic [WordW-1:0]       key_r [4];
  logic [RoundCountW-1:0] round_count_r;
  logic [RoundCountW:0]   rounds_eff;
  logic                   adv;

  logic             valid_w [NumCells+1];
  logic [WordW-1:0] p_w     [NumCells+1];
  logic [WordW-1:0] q_w     [NumCells+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]      <= '0;
      key_r[1]      <= '0;
      key_r[2]      <= '0;
      key_r[3]      <= '0;
      round_count_r <= RoundCountRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_A:       key_r[0] <= cfg_data;
        CFG_KEY_B:       key_r[1] <= cfg_data;
        CFG_KEY_C:       key_r[2] <= cfg_data;
        CFG_KEY_D:       key_r[3] <= cfg_data;
        CFG_ROUND_COUNT: round_count_r <= cfg_data[RoundCountW-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    if ({1'b0, round_count_r} > MaxRoundsW) begin
      rounds_eff = MaxRoundsW;
    end else begin
      rounds_eff = {1'b0, round_count_r};
    end
  end

  assign adv       = !valid_w[NumCells] || out_tready;
  assign in_tready = adv;

  assign valid_w[0] = in_tvalid;
  assign p_w[0]     = in_tdata[WordW-1:0];
  assign q_w[0]     = in_tdata[2*WordW-1:WordW];

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    localparam int unsigned      Round  = i / 2;
    localparam logic [WordW-1:0] CellSum = xtea_sum(Round + (i % 2));
    localparam logic [1:0]       KeySel = (i % 2 == 0) ? CellSum[1:0]
                                                       : CellSum[12:11];
    logic active;

    assign active = (RoundCountW+1)'(Round) < rounds_eff;

    xtea_cell #(
      .SUM (CellSum)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .active    (active),
      .key       (key_r[KeySel]),
      .in_valid  (valid_w[i]),
      .in_p      (p_w[i]),
      .in_q      (q_w[i]),
      .out_valid (valid_w[i+1]),
      .out_p     (p_w[i+1]),
      .out_q     (q_w[i+1])
    );
  end

  assign out_tvalid = valid_w[NumCells];
  assign out_tdata  = {q_w[NumCells], p_w[NumCells]};

endmodule

`default_nettype wire
